// ===== rtl/multiwave_oscillator_crossfade_unit_assert.svh =====
// Assertion macros for the checker of the oscillator.
`ifndef MULTIWAVE_OSCILLATOR_CROSSFADE_UNIT_ASSERT_SVH
`define MULTIWAVE_OSCILLATOR_CROSSFADE_UNIT_ASSERT_SVH

// checked only outside reset
`define MOCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MOCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mocf_pkg.sv =====
package mocf_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 8;
  localparam int SAMPLE_BITS    = 16;

  localparam int FRAC_BITS  = SAMPLE_BITS - 1;
  localparam int TABLE_LEN  = 1 << SINE_ADDR_BITS;
  localparam int PH_UP      = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
  localparam int PH_DN      = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int EXT_BITS   = PHASE_BITS + 32;
  localparam int BLEND_BITS = 17;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CROSSFADE_STEP = 2'd2;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SAW      = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_NOISE    = 3'd4;
  localparam logic [2:0] WAVE_HALF_SQ  = 3'd5;

  localparam logic [31:0] PHASE_STEP_RESET = 32'd42852281;
  localparam logic [15:0] PULSE_RESET      = 16'd32768;
  localparam logic [15:0] PULSE_MIN        = 16'd655;
  localparam logic [15:0] PULSE_MAX        = 16'd64880;
  localparam logic [BLEND_BITS-1:0] XFADE_STEP_RESET = 17'd64;
  localparam logic [BLEND_BITS-1:0] BLEND_ONE        = 17'h10000;
  localparam logic [31:0] LFSR_SEED  = 32'd1;
  localparam logic [31:0] LFSR_POLY  = 32'hD000_0001;
  localparam logic [31:0] PHASE_HALF = 32'h8000_0000;

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [BLEND_BITS-1:0]         blend_t;
  typedef logic [FRAC_BITS-1:0]          sine_rom_t [TABLE_LEN];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] MAX_VAL     = 64'((64'd1 << FRAC_BITS) - 64'd1);
  // (2n)(2n+1) for the Taylor terms of sine
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  // Quarter-wave sine, evaluated at elaboration in Q2.30 fixed point
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t             rom;
    logic [63:0]           x;
    logic [63:0]           x2;
    logic [63:0]           term;
    logic [63:0]           v;
    logic signed [63:0]    sum;
    logic [SINE_ADDR_BITS:0] k;
    logic [2:0]            n;
    for (k = '0; k < (SINE_ADDR_BITS+1)'(TABLE_LEN); k++) begin
      x    = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (SINE_ADDR_BITS + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (n = 3'd0; n < 3'd5; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (n[0] == 1'b0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = ($unsigned(sum) * MAX_VAL + (64'd1 << 29)) >> 30;
      if (v > MAX_VAL) begin
        v = MAX_VAL;
      end
      rom[k[SINE_ADDR_BITS-1:0]] = v[FRAC_BITS-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/multiwave_oscillator_crossfade_unit.sv =====
// Multi-waveform DDS oscillator with linear crossfade between waveforms.
//
// Input channel (in_valid / in_stall): one item per sample tick, carrying
// the waveform select and a phase-restart flag. Result channel (out_valid /
// out_stall): one signed sample per input item, in order.
// Config port (cfg_we / cfg_index / cfg_data): phase step, pulse width
// (clamped on write) and crossfade step; write only while idle.
//
// An accepted item sits in the input register, where the
// whole sample is formed (phase, sine lookup, blend multiply, saturation)
// and all oscillator state advances; the sample then lands in the output
// register once that is free, which raises out_valid; one item is taken
// every cycle while the receiver keeps up.
// When the receiver stalls, the output holds its sample; the input register
// keeps one more item and in_stall rises only if both are full.
// Reset empties both registers, loads the default config, zeroes the
// phase, selects sine with no fade active and seeds the noise LFSR with 1.
module multiwave_oscillator_crossfade_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_wave_select,
  input  logic                                 in_restart_phase,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mocf_pkg::SAMPLE_BITS-1:0] out_sample,
  input  logic                                 cfg_we,
  input  logic [mocf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mocf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int SB  = mocf_pkg::SAMPLE_BITS;
  localparam int F   = mocf_pkg::FRAC_BITS;
  localparam int SAB = mocf_pkg::SINE_ADDR_BITS;
  localparam int PB  = mocf_pkg::PHASE_BITS;

  localparam mocf_pkg::sample_t MAXV = {1'b0, {F{1'b1}}};
  localparam mocf_pkg::sample_t MINV = {1'b1, {F{1'b0}}};

  // config
  logic [31:0]      phase_step_r;
  logic [15:0]      pulse_width_r;
  mocf_pkg::blend_t xfade_step_r;

  // pipeline
  logic             s1_v_r;
  logic [2:0]       s1_sel_r;
  logic             s1_restart_r;
  logic             out_v_r;
  mocf_pkg::sample_t out_sample_r;

  // oscillator state
  mocf_pkg::phase_t accum_r;
  mocf_pkg::blend_t blend_r;
  logic [2:0]       cur_r;
  logic [2:0]       prev_r;
  logic [31:0]      lfsr_r;

  logic out_ready;
  logic s1_adv;
  logic in_take;

  assign out_ready = !out_v_r || !out_stall;
  assign s1_adv    = s1_v_r && out_ready;
  assign in_stall  = s1_v_r && !out_ready;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_sample = out_sample_r;

  function automatic mocf_pkg::sample_t pick_wave(
    input logic [2:0]        code,
    input mocf_pkg::sample_t sine_v,
    input mocf_pkg::sample_t saw_v,
    input mocf_pkg::sample_t sq_v,
    input mocf_pkg::sample_t tri_v,
    input mocf_pkg::sample_t noise_v,
    input mocf_pkg::sample_t half_v
  );
    mocf_pkg::sample_t w;
    unique case (code)
      mocf_pkg::WAVE_SINE:     w = sine_v;
      mocf_pkg::WAVE_SAW:      w = saw_v;
      mocf_pkg::WAVE_SQUARE:   w = sq_v;
      mocf_pkg::WAVE_TRIANGLE: w = tri_v;
      mocf_pkg::WAVE_NOISE:    w = noise_v;
      mocf_pkg::WAVE_HALF_SQ:  w = half_v;
      default:                 w = '0;
    endcase
    return w;
  endfunction

  // per-item datapath
  logic                   changed;
  logic [2:0]             prev_eff;
  mocf_pkg::blend_t       blend_eff;
  mocf_pkg::phase_t       accum_eff;
  logic [31:0]            ph;
  logic                   fading;
  logic                   use_noise;
  logic [31:0]            lfsr_step;
  logic [1:0]             quad;
  logic [SAB-1:0]         sidx;
  mocf_pkg::sample_t      sine_v;
  logic [SB-1:0]          saw_top;
  mocf_pkg::sample_t      saw_v;
  mocf_pkg::sample_t      sq_v;
  logic [31:0]            tri_d;
  logic [F+1:0]           tri_sh;
  mocf_pkg::sample_t      tri_v;
  mocf_pkg::sample_t      noise_v;
  mocf_pkg::sample_t      half_v;
  mocf_pkg::sample_t      wave_a;
  mocf_pkg::sample_t      wave_b;
  logic signed [SB:0]     diff;
  logic signed [SB+18:0]  prod;
  logic signed [SB+1:0]   part;
  logic signed [SB+1:0]   mix;
  mocf_pkg::sample_t      mix_sat;
  mocf_pkg::blend_t       step_eff;
  logic [17:0]            blend_sum;

  mocf_pkg::phase_t       accum_nxt;
  mocf_pkg::blend_t       blend_nxt;
  logic [31:0]            lfsr_nxt;
  mocf_pkg::sample_t      sample_nxt;
  mocf_pkg::phase_t       step_al;

  always_comb begin
    changed   = s1_sel_r != cur_r;
    prev_eff  = changed ? cur_r : prev_r;
    blend_eff = changed ? '0 : blend_r;
    accum_eff = s1_restart_r ? '0 : accum_r;
    ph        = 32'((mocf_pkg::EXT_BITS'(accum_eff) << mocf_pkg::PH_DN) >> mocf_pkg::PH_UP);
    fading    = blend_eff != mocf_pkg::BLEND_ONE;
    use_noise = (s1_sel_r == mocf_pkg::WAVE_NOISE) ||
                (fading && prev_eff == mocf_pkg::WAVE_NOISE);

    lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ mocf_pkg::LFSR_POLY) : (lfsr_r >> 1);
    noise_v   = $signed(lfsr_step[31 -: SB]);

    // sine: quadrant from top bits, odd quadrants mirrored, upper half negated
    quad   = ph[31:30];
    sidx   = ph[29 -: SAB];
    if (quad[0]) begin
      sidx = ~sidx;
    end
    sine_v = $signed({1'b0, mocf_pkg::SINE_ROM[sidx]});
    if (quad[1]) begin
      sine_v = -sine_v;
    end

    saw_top = ph[31 -: SB];
    saw_v   = $signed({~saw_top[SB-1], saw_top[SB-2:0]});

    sq_v   = (ph < {pulse_width_r, 16'h0000}) ? MAXV : MINV;
    half_v = (ph < mocf_pkg::PHASE_HALF) ? MAXV : MINV;

    tri_d  = ph[31] ? (ph - mocf_pkg::PHASE_HALF) : (mocf_pkg::PHASE_HALF - ph);
    tri_sh = (F+2)'(tri_d >> (30 - F));
    tri_v  = tri_sh[F+1] ? MAXV : $signed({~tri_sh[F], tri_sh[F-1:0]});

    wave_a = pick_wave(prev_eff, sine_v, saw_v, sq_v, tri_v, noise_v, half_v);
    wave_b = pick_wave(s1_sel_r, sine_v, saw_v, sq_v, tri_v, noise_v, half_v);

    // a + floor(blend * (b - a) / 2^16)
    diff = (SB+1)'(wave_b) - (SB+1)'(wave_a);
    prod = $signed({1'b0, blend_eff}) * diff;
    part = (SB+2)'(prod >>> 16);
    mix  = (SB+2)'(wave_a) + part;
    if (mix > (SB+2)'(MAXV)) begin
      mix_sat = MAXV;
    end else if (mix < (SB+2)'(MINV)) begin
      mix_sat = MINV;
    end else begin
      mix_sat = SB'(mix);
    end

    step_eff  = (xfade_step_r == '0) ? mocf_pkg::BLEND_BITS'(1) : xfade_step_r;
    blend_sum = 18'(blend_eff) + 18'(step_eff);

    sample_nxt = fading ? mix_sat : wave_b;
    blend_nxt  = (!fading || blend_sum > 18'(mocf_pkg::BLEND_ONE)) ?
                 mocf_pkg::BLEND_ONE : blend_sum[16:0];
    step_al    = PB'((mocf_pkg::EXT_BITS'(phase_step_r) << mocf_pkg::PH_UP) >> mocf_pkg::PH_DN);
    accum_nxt  = accum_eff + step_al;
    lfsr_nxt   = use_noise ? lfsr_step : lfsr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= mocf_pkg::PHASE_STEP_RESET;
      pulse_width_r <= mocf_pkg::PULSE_RESET;
      xfade_step_r  <= mocf_pkg::XFADE_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mocf_pkg::REG_PHASE_STEP: phase_step_r <= cfg_data[31:0];
        mocf_pkg::REG_PULSE_WIDTH: begin
          if (cfg_data[15:0] < mocf_pkg::PULSE_MIN) begin
            pulse_width_r <= mocf_pkg::PULSE_MIN;
          end else if (cfg_data[15:0] > mocf_pkg::PULSE_MAX) begin
            pulse_width_r <= mocf_pkg::PULSE_MAX;
          end else begin
            pulse_width_r <= cfg_data[15:0];
          end
        end
        mocf_pkg::REG_CROSSFADE_STEP: xfade_step_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      accum_r <= '0;
      blend_r <= mocf_pkg::BLEND_ONE;
      cur_r   <= mocf_pkg::WAVE_SINE;
      prev_r  <= mocf_pkg::WAVE_SINE;
      lfsr_r  <= mocf_pkg::LFSR_SEED;
    end else begin
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
        accum_r <= accum_nxt;
        blend_r <= blend_nxt;
        cur_r   <= s1_sel_r;
        prev_r  <= prev_eff;
        lfsr_r  <= lfsr_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sel_r     <= in_wave_select;
      s1_restart_r <= in_restart_phase;
    end
    if (s1_adv) begin
      out_sample_r <= sample_nxt;
    end
  end

endmodule

// ===== rtl/mocf_checker.sv =====
`include "multiwave_oscillator_crossfade_unit_assert.svh"

module mocf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [mocf_pkg::SAMPLE_BITS-1:0] out_sample
);

  // the one-item input register only backs up behind a stalled result
  `MOCF_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall), "in_stall without stalled output")

  `MOCF_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_sample)), "stalled sample changed")

  `MOCF_ASSERT_ALWAYS(a_reset_empty_out, !rst_n |=> !out_valid, "result valid right after reset")

  `MOCF_ASSERT_ALWAYS(a_reset_ready, !rst_n |=> !in_stall, "input stalled right after reset")

  // a result can only appear after an item went in
  `MOCF_ASSERT(a_no_invented, (!out_valid && !$past(in_valid)) |=> !out_valid, "result with no item")

endmodule

bind multiwave_oscillator_crossfade_unit mocf_checker u_mocf_checker (.*);

// ===== sim/oscillator_checker.sv =====
`timescale 1ns / 1ps

module oscillator_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic [2:0]                              in_wave_select,
  input  logic                                    in_restart_phase,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic signed [mocf_pkg::SAMPLE_BITS-1:0] out_sample,
  input  logic                                    cfg_we,
  input  logic [mocf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [mocf_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output int                                      pending,
  output int                                      failures
);
  import mocf_pkg::*;

  localparam int FS    = 1 << FRAC_BITS;
  localparam int MAXV  = FS - 1;
  localparam int UNITY = BLEND_ONE;

  // programmed settings
  logic [31:0] step_cfg;
  logic [15:0] duty_cfg;
  blend_t      fade_rate;

  // oscillator state
  phase_t      phase;
  int          blend;
  logic [2:0]  wave_now;
  logic [2:0]  wave_old;
  logic [31:0] lfsr;

  int          quarter_sine [TABLE_LEN];
  sample_t     samples_due [$];
  int          bad_count = 0;

  // quarter-wave table: Taylor series of sin in Q2.30, sampled at bin centers
  initial begin : build_quarter_sine
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int k = 0; k < TABLE_LEN; k++) begin
      x    = (HALF_PI_Q30 * longint'(2 * k + 1)) >> (SINE_ADDR_BITS + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) * longint'(MAXV) + (64'd1 << 29)) >> 30;
      if (v > MAXV) begin
        v = MAXV;
      end
      quarter_sine[k] = int'(v);
    end
  end

  function automatic int wave_value(logic [2:0] w, phase_t ph, int noise);
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [31:0]               span;
    int                        v;
    case (w)
      WAVE_SINE: begin
        idx = ph[29 -: SINE_ADDR_BITS];
        if (ph[30]) begin
          idx = ~idx;
        end
        v = ph[31] ? -quarter_sine[idx] : quarter_sine[idx];
      end
      WAVE_SAW: begin
        v = int'(ph >> (32 - SAMPLE_BITS)) - FS;
      end
      WAVE_SQUARE: begin
        v = (ph < {duty_cfg, 16'h0000}) ? MAXV : -FS;
      end
      WAVE_TRIANGLE: begin
        span = (ph >= PHASE_HALF) ? ph - PHASE_HALF : PHASE_HALF - ph;
        v = int'(span >> (30 - FRAC_BITS)) - FS;
        if (v > MAXV) begin
          v = MAXV;
        end
      end
      WAVE_NOISE: begin
        v = noise;
      end
      WAVE_HALF_SQ: begin
        v = (ph < PHASE_HALF) ? MAXV : -FS;
      end
      default: begin
        v = 0;
      end
    endcase
    return v;
  endfunction

  // advances the oscillator by one tick and returns the sample it emits
  function automatic sample_t next_sample(logic [2:0] sel, logic restart);
    phase_t ph;
    int     noise;
    int     a;
    int     b;
    int     r;
    int     rate;
    longint prod;
    bit     fading;
    if (sel != wave_now) begin
      wave_old = wave_now;
      wave_now = sel;
      blend    = 0;
    end
    if (restart) begin
      phase = '0;
    end
    ph     = phase;
    fading = blend < UNITY;
    noise  = 0;
    // LFSR only moves on ticks that actually listen to noise
    if (wave_now == WAVE_NOISE || (fading && wave_old == WAVE_NOISE)) begin
      lfsr  = lfsr[0] ? ((lfsr >> 1) ^ LFSR_POLY) : (lfsr >> 1);
      noise = sample_t'(lfsr[31 -: SAMPLE_BITS]);
    end
    if (fading) begin
      a    = wave_value(wave_old, ph, noise);
      b    = wave_value(wave_now, ph, noise);
      prod = longint'(blend) * longint'(b - a);
      r    = a + int'(prod >>> 16);
      if (r > MAXV) begin
        r = MAXV;
      end
      if (r < -FS) begin
        r = -FS;
      end
      rate  = (fade_rate == '0) ? 1 : int'(fade_rate);
      blend = (blend + rate > UNITY) ? UNITY : blend + rate;
    end else begin
      r = wave_value(wave_now, ph, noise);
    end
    phase = phase + step_cfg;
    return sample_t'(r);
  endfunction

  function automatic void apply_write(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_PHASE_STEP: begin
        step_cfg = data[31:0];
      end
      REG_PULSE_WIDTH: begin
        if (data[15:0] < PULSE_MIN) begin
          duty_cfg = PULSE_MIN;
        end else if (data[15:0] > PULSE_MAX) begin
          duty_cfg = PULSE_MAX;
        end else begin
          duty_cfg = data[15:0];
        end
      end
      REG_CROSSFADE_STEP: begin
        fade_rate = data[BLEND_BITS-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    sample_t expected;
    if (!rst_n) begin
      step_cfg  = PHASE_STEP_RESET;
      duty_cfg  = PULSE_RESET;
      fade_rate = XFADE_STEP_RESET;
      phase     = '0;
      blend     = UNITY;
      wave_now  = WAVE_SINE;
      wave_old  = WAVE_SINE;
      lfsr      = LFSR_SEED;
      samples_due.delete();
    end else begin
      if (cfg_we) begin
        apply_write(cfg_index, cfg_data);
      end
      // drain before fill, so an item never meets its own prediction
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0) begin
          $display("%0t: sample %0d arrived with none expected", $time, out_sample);
          bad_count++;
        end else begin
          expected = samples_due.pop_front();
          if (out_sample !== expected) begin
            $display("%0t: sample expected %0d got %0d", $time, expected, out_sample);
            bad_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        samples_due.push_back(next_sample(in_wave_select, in_restart_phase));
      end
    end
    pending  <= samples_due.size();
    failures <= bad_count;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mocf_pkg::*;

  localparam logic [2:0]                WAVE_SPARE_6 = 3'd6;
  localparam logic [2:0]                WAVE_SPARE_7 = 3'd7;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE    = 2'd3;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  localparam int PHASE_ITEMS = 142;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 10;
  localparam int CYCLE_LIMIT = 200000;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_wave_select   = WAVE_SINE;
  logic                      in_restart_phase = 1'b0;
  logic                      out_valid;
  logic                      out_stall        = 1'b0;
  sample_t                   out_sample;
  logic                      cfg_we           = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index        = REG_PHASE_STEP;
  logic [CFG_DATA_BITS-1:0]  cfg_data         = '0;

  int         pending;
  int         failures;
  int         cycle_count = 0;
  logic       hold_req    = 1'b0;
  logic [2:0] sel_now     = WAVE_SINE;

  multiwave_oscillator_crossfade_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_wave_select   (in_wave_select),
    .in_restart_phase (in_restart_phase),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  oscillator_checker i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_wave_select   (in_wave_select),
    .in_restart_phase (in_restart_phase),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending          (pending),
    .failures         (failures)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multiwave_oscillator_crossfade_unit: mismatch");
      $finish;
    end
  end

  // result side: changing stall moods, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int left;
    int waited;
    bit held;
    mode = STALL_NONE;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (waited = 0; waited < HOLD_CYCLES; waited++) begin
          @(posedge clk);
        end
      end
      if (left == 0) begin
        mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= left[1];
      endcase
    end
  end

  // holds the item on the bus until the block takes it
  task automatic send_item(logic [2:0] sel, logic restart);
    in_valid         <= 1'b1;
    in_wave_select   <= sel;
    in_restart_phase <= restart;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] step, logic [31:0] duty, logic [31:0] rate,
                           int change_pct, bit squeeze);
    int left;
    int burst;
    int gap;
    wait_idle();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_PULSE_WIDTH, duty);
    write_reg(REG_CROSSFADE_STEP, rate);
    write_reg(REG_SPARE, $urandom());
    cfg_we <= 1'b0;
    if (squeeze) begin
      hold_req <= 1'b1;
    end
    left = PHASE_ITEMS;
    while (left > 0) begin
      burst = squeeze ? PHASE_ITEMS : $urandom_range(1, 40);
      while (burst > 0 && left > 0) begin
        // long runs on one waveform let fades finish before the next switch
        if ($urandom_range(0, 99) < change_pct) begin
          sel_now = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
        end
        send_item(sel_now, $urandom_range(0, 31) == 0);
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every waveform and the unused selects, restarts, repeats, switches mid-fade
    send_item(WAVE_SINE, 1'b1);
    send_item(WAVE_SINE, 1'b0);
    send_item(WAVE_SAW, 1'b0);
    send_item(WAVE_SQUARE, 1'b0);
    send_item(WAVE_TRIANGLE, 1'b0);
    send_item(WAVE_NOISE, 1'b0);
    send_item(WAVE_NOISE, 1'b0);
    send_item(WAVE_HALF_SQ, 1'b0);
    send_item(WAVE_SPARE_6, 1'b0);
    send_item(WAVE_SPARE_7, 1'b1);
    send_item(WAVE_SPARE_7, 1'b0);
    send_item(WAVE_TRIANGLE, 1'b1);
    send_item(WAVE_NOISE, 1'b0);
    send_item(WAVE_SINE, 1'b0);
    send_item(WAVE_SAW, 1'b1);
    send_item(WAVE_SAW, 1'b0);
    send_item(WAVE_HALF_SQ, 1'b0);
    send_item(WAVE_SQUARE, 1'b1);
    send_item(WAVE_NOISE, 1'b0);
    send_item(WAVE_SINE, 1'b1);
    in_valid <= 1'b0;

    run_phase($urandom_range(1, 32'h0200_0000), 32'd0, 32'd8192, 3, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 4, 1'b0);
    run_phase(32'd0, 32'd655, 32'hFFFF_FFFF, 6, 1'b0);
    run_phase($urandom(), 32'd64880, 32'd65536, 8, 1'b0);
    run_phase($urandom(), $urandom(), 32'd1, 2, 1'b0);
    run_phase($urandom(), $urandom_range(655, 64880), $urandom_range(1, 4096), 5, 1'b1);
    run_phase(32'h8000_0000, 32'd32768, 32'd4096, 5, 1'b0);
    run_phase($urandom(), $urandom(), $urandom(), 10, 1'b0);

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("multiwave_oscillator_crossfade_unit: match");
    end else begin
      $display("multiwave_oscillator_crossfade_unit: mismatch");
    end
    $finish;
  end

endmodule
